/* src/flvf_pkg.sv */
`default_nettype none

package flvf_pkg;

	// Command codes carried by a request.
	localparam logic [1:0] CMD_FILE_HDR = 2'd0;
	localparam logic [1:0] CMD_SEQ_OPEN = 2'd1;
	localparam logic [1:0] CMD_PIC_OPEN = 2'd2;
	localparam logic [1:0] CMD_PAYLOAD  = 2'd3;

	// Kinds of byte run that the back end produces.
	localparam logic [2:0] KIND_ERR  = 3'd0;
	localparam logic [2:0] KIND_FHDR = 3'd1;
	localparam logic [2:0] KIND_SEQ  = 3'd2;
	localparam logic [2:0] KIND_PIC  = 3'd3;
	localparam logic [2:0] KIND_PAY  = 3'd4;

	// Stream constants.
	localparam logic [7:0] SIG_F          = 8'h46;
	localparam logic [7:0] SIG_L          = 8'h4c;
	localparam logic [7:0] SIG_V          = 8'h56;
	localparam logic [7:0] TAG_TYPE_VIDEO = 8'h09;
	localparam logic [7:0] VID_KEY_AVC    = 8'h17;
	localparam logic [7:0] VID_INTER_AVC  = 8'h27;
	localparam logic [7:0] NAL_LEN_SIZE   = 8'hff;
	localparam logic [7:0] SPS_COUNT      = 8'he1;

	typedef struct packed {
		logic [1:0]  command;
		logic        key_frame;
		logic [31:0] timestamp;
		logic [23:0] first_length;
		logic [15:0] second_length;
		logic [7:0]  profile_byte;
		logic [7:0]  compat_byte;
		logic [7:0]  level_byte;
		logic [7:0]  payload_byte;
	} flvf_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       tag_end;
		logic       error;
	} flvf_out_t;

	// One classified request, as handed from the front end to the back end.
	typedef struct packed {
		logic [2:0]  kind;
		logic        do_pps;
		logic        do_trailer;
		logic        key_frame;
		logic [31:0] timestamp;
		logic [23:0] data_size;
		logic [23:0] first_length;
		logic [15:0] pps_len;
		logic [7:0]  profile_byte;
		logic [7:0]  compat_byte;
		logic [7:0]  level_byte;
		logic [7:0]  payload_byte;
		logic [31:0] trailer_size;
	} flvf_job_t;

endpackage

`default_nettype wire

/* src/flvf_front.sv */
`default_nettype none

module flvf_front import flvf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire flvf_in_t  in_data,
	output logic           push_valid,
	input  wire logic      push_ready,
	output flvf_job_t      push_job
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SPS  = 2'd1;
	localparam logic [1:0] PH_PPS  = 2'd2;
	localparam logic [1:0] PH_NALU = 2'd3;

	logic [1:0]  phase_q, phase_d;
	logic [23:0] bytes_left_q, bytes_left_d;
	logic [15:0] pps_count_q, pps_count_d;
	logic [31:0] trailer_size_q, trailer_size_d;
	logic [23:0] seq_body;
	logic [31:0] seq_trailer;
	logic [31:0] pic_body;
	logic [31:0] pic_trailer;
	logic [23:0] bytes_dec;
	logic        accept;
	flvf_job_t   job;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign push_job   = job;
	assign accept     = in_valid && push_ready;

	assign seq_body    = {8'd0, in_data.first_length[15:0]} + {8'd0, in_data.second_length}
		+ 24'd16;
	assign seq_trailer = {8'd0, seq_body} + 32'd11;
	assign pic_body    = {8'd0, in_data.first_length} + 32'd9;
	assign pic_trailer = {8'd0, in_data.first_length} + 32'd20;
	assign bytes_dec   = bytes_left_q - 24'd1;

	always_comb begin
		phase_d        = phase_q;
		bytes_left_d   = bytes_left_q;
		pps_count_d    = pps_count_q;
		trailer_size_d = trailer_size_q;

		job              = '0;
		job.kind         = KIND_ERR;
		job.key_frame    = in_data.key_frame;
		job.timestamp    = in_data.timestamp;
		job.first_length = in_data.first_length;
		job.pps_len      = pps_count_q;
		job.profile_byte = in_data.profile_byte;
		job.compat_byte  = in_data.compat_byte;
		job.level_byte   = in_data.level_byte;
		job.payload_byte = in_data.payload_byte;
		job.trailer_size = trailer_size_q;

		unique case (in_data.command)
			CMD_FILE_HDR: begin
				if (phase_q == PH_IDLE) begin
					job.kind = KIND_FHDR;
				end
			end
			CMD_SEQ_OPEN: begin
				if (phase_q == PH_IDLE && in_data.first_length[23:16] == 8'd0) begin
					job.kind         = KIND_SEQ;
					job.data_size    = seq_body;
					job.trailer_size = seq_trailer;
					job.pps_len      = in_data.second_length;
					trailer_size_d   = seq_trailer;
					pps_count_d      = in_data.second_length;
					if (in_data.first_length == 24'd0) begin
						// Empty SPS: the PPS framing follows at once.
						job.do_pps = 1'b1;
						if (in_data.second_length == 16'd0) begin
							job.do_trailer = 1'b1;
							phase_d        = PH_IDLE;
							bytes_left_d   = 24'd0;
						end else begin
							phase_d      = PH_PPS;
							bytes_left_d = {8'd0, in_data.second_length};
						end
					end else begin
						phase_d      = PH_SPS;
						bytes_left_d = in_data.first_length;
					end
				end
			end
			CMD_PIC_OPEN: begin
				if (phase_q == PH_IDLE) begin
					job.kind         = KIND_PIC;
					job.data_size    = pic_body[23:0];
					job.trailer_size = pic_trailer;
					trailer_size_d   = pic_trailer;
					if (in_data.first_length == 24'd0) begin
						job.do_trailer = 1'b1;
						bytes_left_d   = 24'd0;
					end else begin
						phase_d      = PH_NALU;
						bytes_left_d = in_data.first_length;
					end
				end
			end
			CMD_PAYLOAD: begin
				if (phase_q != PH_IDLE && bytes_left_q != 24'd0) begin
					job.kind     = KIND_PAY;
					bytes_left_d = bytes_dec;
					if (bytes_dec == 24'd0) begin
						if (phase_q == PH_SPS) begin
							job.do_pps = 1'b1;
							if (pps_count_q == 16'd0) begin
								job.do_trailer = 1'b1;
								phase_d        = PH_IDLE;
							end else begin
								phase_d      = PH_PPS;
								bytes_left_d = {8'd0, pps_count_q};
							end
						end else begin
							job.do_trailer = 1'b1;
							phase_d        = PH_IDLE;
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			bytes_left_q   <= 24'd0;
			pps_count_q    <= 16'd0;
			trailer_size_q <= 32'd0;
		end else if (accept) begin
			phase_q        <= phase_d;
			bytes_left_q   <= bytes_left_d;
			pps_count_q    <= pps_count_d;
			trailer_size_q <= trailer_size_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (bytes_left_q == 24'd0))
		else $error("idle phase with payload bytes still due");

	a_open_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (bytes_left_q != 24'd0))
		else $error("open tag with no payload bytes due");
`endif

endmodule

`default_nettype wire

/* src/flvf_queue.sv */
`default_nettype none

module flvf_queue import flvf_pkg::*; #(
	parameter int Depth = 2
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push_valid,
	output logic           push_ready,
	input  wire flvf_job_t push_job,
	output logic           pop_valid,
	input  wire logic      pop_ready,
	output flvf_job_t      pop_job
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	flvf_job_t         entries_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count beyond depth");

	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + CntW'(1)))
		else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

/* src/flvf_back.sv */
`default_nettype none

module flvf_back import flvf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      pop_valid,
	output logic           pop_ready,
	input  wire flvf_job_t pop_job,
	output logic           out_valid,
	input  wire logic      out_ready,
	output flvf_out_t      out_data
);

	localparam logic [1:0] SEG_MAIN = 2'd0;
	localparam logic [1:0] SEG_PPS  = 2'd1;
	localparam logic [1:0] SEG_TRL  = 2'd2;

	flvf_job_t  job_q;
	logic       active_q;
	logic [1:0] seg_q;
	logic [4:0] idx_q;
	logic       out_valid_q;
	flvf_out_t  out_data_q;

	logic [4:0] main_last;
	logic       main_end;
	logic       job_last;
	logic       last_tag_byte;
	logic [7:0] hdr_byte;
	logic [7:0] seq_byte;
	logic [7:0] pic_byte;
	logic [7:0] fhdr_byte;
	logic [7:0] cur_byte;
	logic       emit;
	logic       load;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		unique case (job_q.kind)
			KIND_FHDR: main_last = 5'd12;
			KIND_SEQ:  main_last = 5'd23;
			KIND_PIC:  main_last = 5'd19;
			default:   main_last = 5'd0;
		endcase
	end

	assign main_end = (seg_q == SEG_MAIN) && (idx_q == main_last);

	always_comb begin
		job_last      = 1'b0;
		last_tag_byte = 1'b0;
		unique case (seg_q)
			SEG_MAIN: begin
				job_last      = main_end && !job_q.do_pps && !job_q.do_trailer;
				last_tag_byte = main_end && (job_q.kind == KIND_FHDR);
			end
			SEG_PPS: job_last = (idx_q == 5'd2) && !job_q.do_trailer;
			SEG_TRL: begin
				job_last      = (idx_q == 5'd3);
				last_tag_byte = (idx_q == 5'd3);
			end
			default: job_last = 1'b1;
		endcase
	end

	// Tag header, shared by both tag kinds.
	always_comb begin
		unique case (idx_q)
			5'd0:    hdr_byte = TAG_TYPE_VIDEO;
			5'd1:    hdr_byte = job_q.data_size[23:16];
			5'd2:    hdr_byte = job_q.data_size[15:8];
			5'd3:    hdr_byte = job_q.data_size[7:0];
			5'd4:    hdr_byte = job_q.timestamp[23:16];
			5'd5:    hdr_byte = job_q.timestamp[15:8];
			5'd6:    hdr_byte = job_q.timestamp[7:0];
			5'd7:    hdr_byte = job_q.timestamp[31:24];
			default: hdr_byte = 8'h00;
		endcase
	end

	// Video header, configuration record and SPS framing.
	always_comb begin
		unique case (idx_q)
			5'd11:   seq_byte = VID_KEY_AVC;
			5'd16:   seq_byte = 8'h01;
			5'd17:   seq_byte = job_q.profile_byte;
			5'd18:   seq_byte = job_q.compat_byte;
			5'd19:   seq_byte = job_q.level_byte;
			5'd20:   seq_byte = NAL_LEN_SIZE;
			5'd21:   seq_byte = SPS_COUNT;
			5'd22:   seq_byte = job_q.first_length[15:8];
			5'd23:   seq_byte = job_q.first_length[7:0];
			default: seq_byte = hdr_byte;
		endcase
	end

	// Video header and NALU length.
	always_comb begin
		unique case (idx_q)
			5'd11:   pic_byte = job_q.key_frame ? VID_KEY_AVC : VID_INTER_AVC;
			5'd12:   pic_byte = 8'h01;
			5'd17:   pic_byte = job_q.first_length[23:16];
			5'd18:   pic_byte = job_q.first_length[15:8];
			5'd19:   pic_byte = job_q.first_length[7:0];
			default: pic_byte = hdr_byte;
		endcase
	end

	always_comb begin
		unique case (idx_q)
			5'd0:       fhdr_byte = SIG_F;
			5'd1:       fhdr_byte = SIG_L;
			5'd2:       fhdr_byte = SIG_V;
			5'd3, 5'd4: fhdr_byte = 8'h01;
			5'd8:       fhdr_byte = 8'h09;
			default:    fhdr_byte = 8'h00;
		endcase
	end

	always_comb begin
		cur_byte = 8'h00;
		unique case (seg_q)
			SEG_MAIN: begin
				unique case (job_q.kind)
					KIND_FHDR: cur_byte = fhdr_byte;
					KIND_SEQ:  cur_byte = seq_byte;
					KIND_PIC:  cur_byte = pic_byte;
					KIND_PAY:  cur_byte = job_q.payload_byte;
					default:   cur_byte = 8'h00;
				endcase
			end
			SEG_PPS: begin
				unique case (idx_q)
					5'd0:    cur_byte = 8'h01;
					5'd1:    cur_byte = job_q.pps_len[15:8];
					default: cur_byte = job_q.pps_len[7:0];
				endcase
			end
			SEG_TRL: begin
				unique case (idx_q)
					5'd0:    cur_byte = job_q.trailer_size[31:24];
					5'd1:    cur_byte = job_q.trailer_size[23:16];
					5'd2:    cur_byte = job_q.trailer_size[15:8];
					default: cur_byte = job_q.trailer_size[7:0];
				endcase
			end
			default: cur_byte = 8'h00;
		endcase
	end

	assign emit      = active_q && (!out_valid_q || out_ready);
	assign load      = (!active_q || (emit && job_last)) && pop_valid;
	assign pop_ready = !active_q || (emit && job_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			seg_q    <= SEG_MAIN;
			idx_q    <= 5'd0;
		end else if (load) begin
			active_q <= 1'b1;
			seg_q    <= SEG_MAIN;
			idx_q    <= 5'd0;
		end else if (emit) begin
			if (job_last) begin
				active_q <= 1'b0;
			end else if (main_end) begin
				seg_q <= job_q.do_pps ? SEG_PPS : SEG_TRL;
				idx_q <= 5'd0;
			end else if (seg_q == SEG_PPS && idx_q == 5'd2) begin
				seg_q <= SEG_TRL;
				idx_q <= 5'd0;
			end else begin
				idx_q <= idx_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= pop_job;
		end
		if (emit) begin
			out_data_q.out_byte <= cur_byte;
			out_data_q.run_last <= job_last;
			out_data_q.tag_end  <= last_tag_byte;
			out_data_q.error    <= (job_q.kind == KIND_ERR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_error_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.error) |->
		(out_data_q.run_last && out_data_q.out_byte == 8'h00 && !out_data_q.tag_end))
		else $error("error result is not a lone zero byte");

	a_tag_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.tag_end) |-> out_data_q.run_last)
		else $error("tag end before the end of the run");

	a_trailer_wanted: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && seg_q == SEG_TRL) |-> job_q.do_trailer)
		else $error("trailer emitted for a run that closes no tag");
`endif

endmodule

`default_nettype wire

/* src/flv_video_tag_framer.sv */
// A request's job is queued, then loaded into the back end, whose output is registered. The
// back end emits one stream byte per cycle unless the output stalls; runs are 1 to 31 bytes.
// Requests are taken one per cycle while the job queue (QueueDepth entries) has room,
// so unstalled payload bytes pass at one per cycle; a header run holds the input for its length.
// Reset (arst_n low, asynchronous) closes any open tag, empties the queue, drops output valid.
`default_nettype none

module flv_video_tag_framer import flvf_pkg::*; #(
	parameter int QueueDepth = 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire flvf_in_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output flvf_out_t     out_data
);

	// The front end classifies each request against the tag state it keeps
	// (phase, payload bytes still due, PPS length, previous tag size) and
	// turns it into a job that names the run of bytes to emit: a main part
	// (file header, tag headers, one payload byte or an error), then PPS
	// framing and the previous tag size where the request closes a part.
	// The state moves at acceptance, so the next request is judged at once.
	logic      push_valid;
	logic      push_ready;
	flvf_job_t push_job;

	// Queue between the two halves, so that a long header run in the back
	// end does not stop the front end until the queue fills.
	logic      pop_valid;
	logic      pop_ready;
	flvf_job_t pop_job;

	flvf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	flvf_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// The back end walks the job byte by byte into an output register; it
	// takes the next job in the same cycle that it emits the last byte of
	// the current one, so runs follow each other without a gap.
	flvf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* verif/flv_video_tag_framer_tb.sv */
`default_nettype none

module flv_video_tag_framer_tb;
	import flvf_pkg::*;

	// The run is stopped here if it has not drained by then. The slowest correct run is far
	// shorter: at most about 200 requests, each with its idle gap and a run of at most 31 bytes,
	// each byte behind its own output stall.
	localparam int CYCLE_LIMIT = 500000;
	// Random requests after the directed opening.
	localparam int RANDOM_REQS = 95;
	// Quiet cycles after the last expected byte, to catch stray output.
	localparam int TAIL_CYCLES = 40;

	// Where the open tag stands, as far as the predictor is concerned.
	typedef enum logic [1:0] {
		TAG_CLOSED,
		IN_SPS,
		IN_PPS,
		IN_NALU
	} tag_phase_e;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	flvf_in_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	flvf_out_t out_data;

	flv_video_tag_framer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	// Requests waiting to be driven, and the stream bytes that the accepted ones must produce.
	flvf_in_t  pending[$];
	flvf_out_t stream_exp[$];

	// Predictor copy of the muxer state.
	tag_phase_e  tag_ph = TAG_CLOSED;
	logic [23:0] body_left = '0;
	logic [15:0] pps_len = '0;
	logic [31:0] trailer_exp = '0;

	int          reqs_total = 0;
	int          reqs_taken = 0;
	int          bytes_seen = 0;
	int          tags_closed = 0;
	int          errors_seen = 0;
	int          fails = 0;
	int          cycle_count = 0;
	int          out_wait = 0;

	logic [4:0]  in_gap = '0;
	logic [4:0]  out_stall = '0;
	logic        in_burst = 1'b0;
	logic        out_burst = 1'b1;
	flvf_out_t   want;

	// Both sides idle between handshakes. Now and then a side flips into a burst mode in which
	// it does not idle at all, so that long back-to-back stretches occur as well.
	function automatic int draw_wait(inout logic burst);
		if ($urandom_range(0, 15) == 0)
			burst = ~burst;
		return burst ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic void put_byte(logic [7:0] b, logic last_of_tag);
		flvf_out_t o;
		o.out_byte = b;
		o.run_last = 1'b0;
		o.tag_end  = last_of_tag;
		o.error    = 1'b0;
		stream_exp.push_back(o);
	endfunction

	// Tag header: type, 24-bit data size, timestamp low 24 bits then high 8, stream id zero.
	function automatic void put_tag_header(logic [23:0] data_size, logic [31:0] ts);
		put_byte(TAG_TYPE_VIDEO, 1'b0);
		put_byte(data_size[23:16], 1'b0);
		put_byte(data_size[15:8], 1'b0);
		put_byte(data_size[7:0], 1'b0);
		put_byte(ts[23:16], 1'b0);
		put_byte(ts[15:8], 1'b0);
		put_byte(ts[7:0], 1'b0);
		put_byte(ts[31:24], 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
	endfunction

	// Previous tag size closes the tag; its last byte carries the tag end mark.
	function automatic void put_prev_size();
		put_byte(trailer_exp[31:24], 1'b0);
		put_byte(trailer_exp[23:16], 1'b0);
		put_byte(trailer_exp[15:8], 1'b0);
		put_byte(trailer_exp[7:0], 1'b1);
		tag_ph = TAG_CLOSED;
		body_left = '0;
		tags_closed++;
	endfunction

	// PPS framing follows the last SPS byte. An empty PPS closes the tag at once.
	function automatic void put_pps_framing();
		put_byte(8'h01, 1'b0);
		put_byte(pps_len[15:8], 1'b0);
		put_byte(pps_len[7:0], 1'b0);
		tag_ph = IN_PPS;
		body_left = {8'd0, pps_len};
		if (body_left == 0)
			put_prev_size();
	endfunction

	function automatic void put_error();
		flvf_out_t o;
		o = '0;
		o.error = 1'b1;
		stream_exp.push_back(o);
		errors_seen++;
	endfunction

	// Works out the byte run that one accepted request must produce.
	function automatic void predict_run(flvf_in_t r);
		logic [31:0] body;
		flvf_out_t   last;
		case (r.command)
			CMD_FILE_HDR: begin
				if (tag_ph != TAG_CLOSED) begin
					put_error();
				end else begin
					put_byte(SIG_F, 1'b0);
					put_byte(SIG_L, 1'b0);
					put_byte(SIG_V, 1'b0);
					put_byte(8'h01, 1'b0);
					put_byte(8'h01, 1'b0);
					put_byte(8'h00, 1'b0);
					put_byte(8'h00, 1'b0);
					put_byte(8'h00, 1'b0);
					put_byte(8'h09, 1'b0);
					put_byte(8'h00, 1'b0);
					put_byte(8'h00, 1'b0);
					put_byte(8'h00, 1'b0);
					put_byte(8'h00, 1'b1);
					tags_closed++;
				end
			end
			CMD_SEQ_OPEN: begin
				// An SPS longer than 16 bits can carry is refused like a misplaced request.
				if (tag_ph != TAG_CLOSED || r.first_length[23:16] != 0) begin
					put_error();
				end else begin
					body = {16'd0, r.first_length[15:0]} + {16'd0, r.second_length} + 32'd16;
					trailer_exp = body + 32'd11;
					pps_len = r.second_length;
					put_tag_header(body[23:0], r.timestamp);
					put_byte(VID_KEY_AVC, 1'b0);
					put_byte(8'h00, 1'b0);
					put_byte(8'h00, 1'b0);
					put_byte(8'h00, 1'b0);
					put_byte(8'h00, 1'b0);
					put_byte(8'h01, 1'b0);
					put_byte(r.profile_byte, 1'b0);
					put_byte(r.compat_byte, 1'b0);
					put_byte(r.level_byte, 1'b0);
					put_byte(NAL_LEN_SIZE, 1'b0);
					put_byte(SPS_COUNT, 1'b0);
					put_byte(r.first_length[15:8], 1'b0);
					put_byte(r.first_length[7:0], 1'b0);
					tag_ph = IN_SPS;
					body_left = r.first_length;
					if (body_left == 0)
						put_pps_framing();
				end
			end
			CMD_PIC_OPEN: begin
				if (tag_ph != TAG_CLOSED) begin
					put_error();
				end else begin
					// The header's data size wraps at 24 bits; the trailer keeps all 32.
					body = {8'd0, r.first_length} + 32'd9;
					trailer_exp = body + 32'd11;
					put_tag_header(body[23:0], r.timestamp);
					put_byte(r.key_frame ? VID_KEY_AVC : VID_INTER_AVC, 1'b0);
					put_byte(8'h01, 1'b0);
					put_byte(8'h00, 1'b0);
					put_byte(8'h00, 1'b0);
					put_byte(8'h00, 1'b0);
					put_byte(8'h00, 1'b0);
					put_byte(r.first_length[23:16], 1'b0);
					put_byte(r.first_length[15:8], 1'b0);
					put_byte(r.first_length[7:0], 1'b0);
					tag_ph = IN_NALU;
					body_left = r.first_length;
					if (body_left == 0)
						put_prev_size();
				end
			end
			default: begin
				if (tag_ph == TAG_CLOSED || body_left == 0) begin
					put_error();
				end else begin
					put_byte(r.payload_byte, 1'b0);
					body_left = body_left - 24'd1;
					if (body_left == 0) begin
						if (tag_ph == IN_SPS)
							put_pps_framing();
						else
							put_prev_size();
					end
				end
			end
		endcase
		// Every request produces at least one byte; the last one of the run is marked.
		last = stream_exp.pop_back();
		last.run_last = 1'b1;
		stream_exp.push_back(last);
	endfunction

	// A request of the given command with every other field random.
	function automatic flvf_in_t fresh(logic [1:0] cmd);
		flvf_in_t r;
		r.command       = cmd;
		r.key_frame     = 1'($urandom_range(0, 1));
		r.timestamp     = $urandom;
		r.first_length  = 24'($urandom);
		r.second_length = 16'($urandom);
		r.profile_byte  = 8'($urandom);
		r.compat_byte   = 8'($urandom);
		r.level_byte    = 8'($urandom);
		r.payload_byte  = 8'($urandom);
		return r;
	endfunction

	// Payload bytes of a tag body, with an occasional misplaced opener mixed in.
	function automatic void queue_body(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 7) == 0)
				pending.push_back(fresh(2'($urandom_range(0, 2))));
			pending.push_back(fresh(CMD_PAYLOAD));
		end
	endfunction

	// Noise while no tag is open: a stray payload byte or an SPS that is too long.
	function automatic void queue_idle_noise();
		flvf_in_t r;
		if ($urandom_range(0, 1) == 0) begin
			r = fresh(CMD_PAYLOAD);
		end else begin
			r = fresh(CMD_SEQ_OPEN);
			r.first_length = 24'($urandom_range(32'h10000, 32'hffffff));
		end
		pending.push_back(r);
	endfunction

	// Driver: presents one request at a time and predicts its run when it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_run(in_data);
				reqs_taken++;
			end
			if (in_valid && !in_ready) begin
				// Hold the request and its payload until it is taken.
			end else if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 5'd1;
			end else if (pending.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= pending.pop_front();
				in_gap <= 5'(draw_wait(in_burst));
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	function automatic void check_field(string what, logic [7:0] exp_v, logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, exp_v, act_v);
			fails++;
		end
	endfunction

	// Monitor: takes stream bytes with random stalls and checks each against the oldest
	// expectation. A stall of zero keeps ready high, so bytes can be taken back to back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= '0;
		end else begin
			if (out_valid && out_ready) begin
				bytes_seen++;
				if (stream_exp.size() == 0) begin
					$display("%0t: unexpected byte, expected none, actual %02h run_last %b tag_end %b error %b",
						$time, out_data.out_byte, out_data.run_last, out_data.tag_end,
						out_data.error);
					fails++;
				end else begin
					want = stream_exp.pop_front();
					check_field("out_byte", want.out_byte, out_data.out_byte);
					check_field("run_last", 8'(want.run_last), 8'(out_data.run_last));
					check_field("tag_end", 8'(want.tag_end), 8'(out_data.tag_end));
					check_field("error", 8'(want.error), 8'(out_data.error));
				end
				out_wait = draw_wait(out_burst);
				out_stall <= (out_wait == 0) ? 5'd0 : 5'(out_wait - 1);
				out_ready <= (out_wait == 0);
			end else if (out_stall != 0) begin
				out_ready <= 1'b0;
				out_stall <= out_stall - 5'd1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d requests taken of %0d and %0d bytes outstanding",
				$time, reqs_taken, reqs_total, stream_exp.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		flvf_in_t r;
		int       n1;
		int       n2;
		int       pick;
		int       directed;

		// Directed opening. A payload byte with no tag open is an error.
		r = fresh(CMD_PAYLOAD);
		r = '1;
		pending.push_back(r);
		r = '0;
		r.command = CMD_FILE_HDR;
		pending.push_back(r);
		// Empty SPS and empty PPS: the whole tag, trailer included, comes from one request.
		r = '0;
		r.command = CMD_SEQ_OPEN;
		pending.push_back(r);
		// Empty NALU on a key frame with the largest timestamp.
		r = fresh(CMD_PIC_OPEN);
		r.key_frame = 1'b1;
		r.timestamp = 32'hffffffff;
		r.first_length = 24'd0;
		pending.push_back(r);
		// Sequence header with one SPS byte and two PPS bytes, openers misplaced in between.
		r = fresh(CMD_SEQ_OPEN);
		r.first_length = 24'd1;
		r.second_length = 16'd2;
		r.profile_byte = 8'hff;
		r.compat_byte = 8'hff;
		r.level_byte = 8'hff;
		r.timestamp = 32'h12345678;
		pending.push_back(r);
		pending.push_back(fresh(CMD_FILE_HDR));
		r = fresh(CMD_PAYLOAD);
		r.payload_byte = 8'h00;
		pending.push_back(r);
		r = fresh(CMD_SEQ_OPEN);
		r.first_length = 24'd0;
		pending.push_back(r);
		r = fresh(CMD_PAYLOAD);
		r.payload_byte = 8'hff;
		pending.push_back(r);
		pending.push_back(fresh(CMD_PIC_OPEN));
		pending.push_back(fresh(CMD_PAYLOAD));
		// SPS one past the 16-bit limit.
		r = fresh(CMD_SEQ_OPEN);
		r.first_length = 24'h010000;
		pending.push_back(r);
		// Empty SPS, one PPS byte.
		r = fresh(CMD_SEQ_OPEN);
		r.first_length = 24'd0;
		r.second_length = 16'd1;
		pending.push_back(r);
		pending.push_back(fresh(CMD_PAYLOAD));
		// Two SPS bytes, empty PPS: the last SPS byte brings framing and trailer together.
		r = fresh(CMD_SEQ_OPEN);
		r.first_length = 24'd2;
		r.second_length = 16'd0;
		pending.push_back(r);
		pending.push_back(fresh(CMD_PAYLOAD));
		pending.push_back(fresh(CMD_PAYLOAD));
		// One-byte NALU on an inter frame.
		r = fresh(CMD_PIC_OPEN);
		r.key_frame = 1'b0;
		r.timestamp = 32'h80000000;
		r.first_length = 24'd1;
		pending.push_back(r);
		pending.push_back(fresh(CMD_PAYLOAD));
		r = fresh(CMD_FILE_HDR);
		pending.push_back(r);
		directed = pending.size();

		// Random part: mostly well-formed tags with random content, some noise at idle.
		while (pending.size() < directed + RANDOM_REQS) begin
			pick = $urandom_range(0, 19);
			if (pick < 2) begin
				pending.push_back(fresh(CMD_FILE_HDR));
			end else if (pick < 4) begin
				queue_idle_noise();
			end else if (pick < 9) begin
				n1 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 3);
				n2 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 3);
				r = fresh(CMD_SEQ_OPEN);
				r.first_length = 24'(n1);
				r.second_length = 16'(n2);
				pending.push_back(r);
				queue_body(n1);
				queue_body(n2);
			end else begin
				n1 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
				r = fresh(CMD_PIC_OPEN);
				r.first_length = 24'(n1);
				pending.push_back(r);
				queue_body(n1);
			end
		end

		// An overlong NALU can never be finished within the run, so it goes last: its header
		// size wraps, and the tag stays open for the few bytes and the misplaced opener after it.
		r = fresh(CMD_PIC_OPEN);
		r.first_length = 24'hffffff;
		pending.push_back(r);
		pending.push_back(fresh(CMD_PAYLOAD));
		pending.push_back(fresh(CMD_SEQ_OPEN));
		pending.push_back(fresh(CMD_PAYLOAD));
		reqs_total = pending.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (reqs_taken < reqs_total || stream_exp.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Drove %0d requests and checked %0d stream bytes.", reqs_taken, bytes_seen);
		$display("Headers and tags closed: %0d, error responses: %0d.", tags_closed,
			errors_seen);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
